@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg
// Constants, types and helpers of the life grid stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int LINE_LEN = MAX_COLS + 2;
   localparam int COL_W    = $clog2(LINE_LEN);
   localparam int ROW_W    = $clog2(MAX_ROWS + 2);
   localparam int CFG_W    = 11;

   localparam logic REG_COLS = 1'b0;
   localparam logic REG_ROWS = 1'b1;

   typedef struct packed {
      logic accept;
      logic emit;
      logic row_end;
      logic grid_end;
      logic restart;
   } step_type;

   // last padded column index: clamp(v, 1, MAX_COLS) + 1
   function automatic logic [COL_W-1:0] col_last(input logic [CFG_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) begin
         r = COL_W'(1);
      end else if (32'(v) > MAX_COLS) begin
         r = COL_W'(MAX_COLS);
      end else begin
         r = COL_W'(v);
      end
      return r + COL_W'(1);
   endfunction

   function automatic logic [ROW_W-1:0] row_last(input logic [CFG_W-1:0] v);
      logic [ROW_W-1:0] r;
      if (v == '0) begin
         r = ROW_W'(1);
      end else if (32'(v) > MAX_ROWS) begin
         r = ROW_W'(MAX_ROWS);
      end else begin
         r = ROW_W'(v);
      end
      return r + ROW_W'(1);
   endfunction

   function automatic logic [3:0] popcount9(input logic [8:0] v);
      logic [3:0] n;
      n = '0;
      for (int k = 0; k < 9; k++) begin
         n = n + 4'(v[k]);
      end
      return n;
   endfunction

endpackage

@@ rtl/lgs_line_ram.sv @@
// ----------------------------------------------------------------------------
// lgs_line_ram
// Two line buffers packed into one entry per padded column: bit 0 holds the
// row above, bit 1 the row two above. One write, one registered read.
// ----------------------------------------------------------------------------
module lgs_line_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [lgs_pkg::COL_W-1:0] wr_addr,
   input  logic [1:0]                wr_data,
   input  logic [lgs_pkg::COL_W-1:0] rd_addr,
   output logic [1:0]                rd_data
);

   logic [1:0] mem [lgs_pkg::LINE_LEN];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lgs_window.sv @@
// ----------------------------------------------------------------------------
// lgs_window
// 3x3 window shift register, B3/S23 rule and output register.
// ----------------------------------------------------------------------------
module lgs_window (
   input  logic              clock,
   input  logic              reset,
   input  lgs_pkg::step_type step,
   input  logic [2:0]        column,
   input  logic              rsp_ready,
   output logic              out_free,
   output logic              rsp_valid,
   output logic              rsp_next_cell,
   output logic              rsp_end_of_grid
);

   logic [8:0] window_ff, window_in, window_shift;
   logic       valid_ff, valid_in;
   logic       next_ff, next_in;
   logic       eog_ff, eog_in;
   logic [3:0] total;
   logic       load;

   assign window_shift = {window_ff[5:0], column};
   assign total        = lgs_pkg::popcount9(window_shift);
   assign load         = step.accept & step.emit;
   assign out_free     = ~valid_ff | rsp_ready;

   always_comb begin
      window_in = window_ff;
      if (step.restart) begin
         window_in = '0;
      end else if (step.accept) begin
         window_in = step.row_end ? '0 : window_shift;
      end
   end

   always_comb begin
      next_in  = next_ff;
      eog_in   = eog_ff;
      valid_in = valid_ff & ~rsp_ready;
      if (load) begin
         valid_in = 1'b1;
         eog_in   = step.grid_end;
         if (total == 4'd3) begin
            next_in = 1'b1;
         end else if (total == 4'd4) begin
            next_in = window_shift[4];
         end else begin
            next_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         window_ff <= window_in;
         valid_ff  <= valid_in;
      end
      next_ff <= next_in;
      eog_ff  <= eog_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_next_cell   = next_ff;
   assign rsp_end_of_grid = eog_ff;

endmodule

@@ rtl/life_grid_step_stencil.sv @@
// Latency: a result appears the cycle after its cell is transferred in.
// Throughput: one cell per cycle unless a result waits on rsp_ready; the line
// RAM prefetches the next column; each transfer finds its column registered.
// Halo cells (first two rows, first two columns of a row) give no result.
// Reset: synchronous; positions and window clear, limits go to 1024 x 1024,
// the line RAM is not cleared.
// ----------------------------------------------------------------------------
// life_grid_step_stencil
// Streaming B3/S23 next-generation stencil over a halo-padded raster grid.
// ----------------------------------------------------------------------------
module life_grid_step_stencil (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cell_req,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_next_cell,
   output logic                      rsp_end_of_grid,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [lgs_pkg::CFG_W-1:0] csr_wdata
);

   logic [lgs_pkg::COL_W-1:0] col_ff, col_in, last_col_ff, last_col_in;
   logic [lgs_pkg::ROW_W-1:0] row_ff, row_in, last_row_ff, last_row_in;
   logic                      accept, restart, col_end, row_end;
   logic                      out_free;
   logic [1:0]                rd_data;
   lgs_pkg::step_type         step;

   assign accept    = req_valid & req_ready;
   assign req_ready = out_free;
   assign col_end   = col_ff == last_col_ff;
   assign row_end   = row_ff == last_row_ff;

   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      restart     = 1'b0;
      if (csr_we) begin
         case (csr_index)
            lgs_pkg::REG_COLS: begin
               last_col_in = lgs_pkg::col_last(csr_wdata);
               restart     = 1'b1;
            end
            lgs_pkg::REG_ROWS: begin
               last_row_in = lgs_pkg::row_last(csr_wdata);
               restart     = 1'b1;
            end
            default: restart = 1'b0;
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + lgs_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + lgs_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         last_col_ff <= lgs_pkg::col_last(lgs_pkg::CFG_W'(lgs_pkg::MAX_COLS));
         last_row_ff <= lgs_pkg::row_last(lgs_pkg::CFG_W'(lgs_pkg::MAX_ROWS));
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

   // entry: bit 0 row above, bit 1 two rows above; shift down on write
   lgs_line_ram u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data ({rd_data[0], req_cell_req}),
      .rd_addr (col_in),
      .rd_data (rd_data)
   );

   always_comb begin
      step.accept   = accept;
      step.emit     = (row_ff >= lgs_pkg::ROW_W'(2)) & (col_ff >= lgs_pkg::COL_W'(2));
      step.row_end  = col_end;
      step.grid_end = col_end & row_end;
      step.restart  = restart;
   end

   lgs_window u_window (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .column          ({req_cell_req, rd_data[0], rd_data[1]}),
      .rsp_ready       (rsp_ready),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_next_cell   (rsp_next_cell),
      .rsp_end_of_grid (rsp_end_of_grid)
   );

endmodule

@@ rtl/lgs_checker.sv @@
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks on the life grid stencil, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lgs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_next_cell,
   input logic rsp_end_of_grid
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_next_cell) && $stable(rsp_end_of_grid), "rsp payload changed")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "rsp valid after reset")
   `ASSERT_CLK(a_rsp_source, clock, reset, rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready), "rsp without req transfer")

endmodule

bind life_grid_step_stencil lgs_checker u_lgs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_next_cell   (rsp_next_cell),
   .rsp_end_of_grid (rsp_end_of_grid)
);

@@ test/stencil_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stencil_checker
// Watches the cell, result and register ports of the life stencil, predicts
// the next generation of every inner cell from the transferred cells and the
// grid size, and compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
module stencil_checker
   import lgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_cell_req,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             rsp_next_cell,
   input  logic             rsp_end_of_grid,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int               mismatches,
   output int               outstanding,
   output int               checked,
   output int               grid_ends
);

   typedef struct packed {
      logic next_cell;
      logic end_of_grid;
   } next_gen_t;

   next_gen_t        next_gen_q[$];
   logic [CFG_W-1:0] cols_reg;
   logic [CFG_W-1:0] rows_reg;
   logic [COL_W-1:0] col_pos;
   logic [ROW_W-1:0] row_pos;
   logic [8:0]       window;
   bit               near_row [LINE_LEN];
   bit               far_row [LINE_LEN];
   int               err_n;
   int               checked_n;
   int               ends_n;

   function automatic int unsigned grid_span(input logic [CFG_W-1:0] v,
                                             input int unsigned limit);
      if (v == '0) return 1;
      if (v > limit) return limit;
      return 32'(v);
   endfunction

   // one padded-grid cell in; queues the next state when the window is inner
   function automatic void step_stencil(input logic alive);
      int unsigned width;
      int unsigned height;
      int unsigned c;
      int unsigned r;
      logic        up1;
      logic        up2;
      next_gen_t   res;
      width  = grid_span(cols_reg, MAX_COLS) + 2;
      height = grid_span(rows_reg, MAX_ROWS) + 2;
      c = (col_pos >= width) ? width - 1 : col_pos;
      r = (row_pos >= height) ? height - 1 : row_pos;
      up1 = near_row[c];
      up2 = far_row[c];
      far_row[c]  = up1;
      near_row[c] = alive;
      // newest column in bits 2:0, bottom cell on top
      window = {window[5:0], alive, up1, up2};
      if (r >= 2 && c >= 2) begin
         case ($countones(window))
            3:       res.next_cell = 1'b1;
            4:       res.next_cell = window[4];
            default: res.next_cell = 1'b0;
         endcase
         res.end_of_grid = (r == height - 1) && (c == width - 1);
         next_gen_q = {next_gen_q, res};
      end
      if (c + 1 >= width) begin
         col_pos = '0;
         window  = '0;
         row_pos = (r + 1 >= height) ? '0 : ROW_W'(r + 1);
      end else begin
         col_pos = COL_W'(c + 1);
         row_pos = ROW_W'(r);
      end
   endfunction

   always @(posedge clock) begin
      next_gen_t want;
      if (reset) begin
         next_gen_q.delete();
         cols_reg = CFG_W'(MAX_COLS);
         rows_reg = CFG_W'(MAX_ROWS);
         col_pos  = '0;
         row_pos  = '0;
         window   = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (next_gen_q.size() == 0) begin
               $error("unexpected result transfer: next_cell=%0b end_of_grid=%0b",
                      rsp_next_cell, rsp_end_of_grid);
               err_n++;
            end else begin
               want = next_gen_q.pop_front();
               if (rsp_next_cell !== want.next_cell) begin
                  $error("next_cell: expected %0b, got %0b", want.next_cell, rsp_next_cell);
                  err_n++;
               end
               if (rsp_end_of_grid !== want.end_of_grid) begin
                  $error("end_of_grid: expected %0b, got %0b",
                         want.end_of_grid, rsp_end_of_grid);
                  err_n++;
               end
               checked_n++;
               if (want.end_of_grid) ends_n++;
            end
         end
         if (csr_we) begin
            if (csr_index == REG_COLS) begin
               cols_reg = csr_wdata;
            end else begin
               rows_reg = csr_wdata;
            end
            col_pos = '0;
            row_pos = '0;
            window  = '0;
         end
         if (req_valid && req_ready) begin
            step_stencil(req_cell_req);
         end
      end
      mismatches  <= err_n;
      outstanding <= next_gen_q.size();
      checked     <= checked_n;
      grid_ends   <= ends_n;
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives halo-padded grids through the life stencil: a partial frame at the
// reset size, small hand-made grids, random sizes and densities, and
// the extreme register values, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
   import lgs_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RANDOM_CELLS    = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT     = 2150;
   localparam int EXTREME_LINES   = 12;

   localparam logic [CFG_W-1:0] EXTREME_COLS [3] = '{11'd0, 11'd1, 11'd0};
   localparam logic [CFG_W-1:0] EXTREME_ROWS [3] = '{11'd2047, 11'd1024, 11'd1025};

   // corner and centre patterns: survival on 2 / survival on 3 / stays dead
   localparam logic [8:0] SHAPES [3] = '{9'b000010101, 9'b100010101, 9'b101000101};

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_cell_req;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_next_cell;
   logic             rsp_end_of_grid;
   logic             csr_we;
   logic             csr_index;
   logic [CFG_W-1:0] csr_wdata;
   logic             hold_off_go;
   logic             hold_off_done;

   int               mismatches;
   int               outstanding;
   int               checked;
   int               grid_ends;
   int               cells_total;
   int               random_cells;
   int               phases;
   bit               send_calm;
   logic [CFG_W-1:0] cur_cols;
   logic [CFG_W-1:0] cur_rows;

   life_grid_step_stencil dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_req    (req_cell_req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_cell   (rsp_next_cell),
      .rsp_end_of_grid (rsp_end_of_grid),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   stencil_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_req    (req_cell_req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_cell   (rsp_next_cell),
      .rsp_end_of_grid (rsp_end_of_grid),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .checked         (checked),
      .grid_ends       (grid_ends)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap(input bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // padded extent for a register value
   function automatic int padded(input logic [CFG_W-1:0] v, input int limit);
      if (v == '0) return 3;
      if (v > limit) return limit + 2;
      return int'(v) + 2;
   endfunction

   task automatic offer_cell(input logic alive);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cell_req <= alive;
      do @(posedge clock); while (!req_ready);
      cells_total++;
   endtask

   // stop offering until every predicted result has been transferred
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic send_cells(input int count, input int live_pct);
      for (int i = 0; i < count; i++) begin
         if (!hold_off_go && cells_total >= HOLD_OFF_AT) hold_off_go <= 1'b1;
         if ($urandom_range(399) == 0) drain();
         offer_cell($urandom_range(99) < live_pct);
      end
   endtask

   task automatic write_regs(input bit set_cols, input logic [CFG_W-1:0] cols,
                             input bit set_rows, input logic [CFG_W-1:0] rows);
      if (set_cols) begin
         csr_we    <= 1'b1;
         csr_index <= REG_COLS;
         csr_wdata <= cols;
         cur_cols   = cols;
         @(posedge clock);
      end
      if (set_rows) begin
         csr_we    <= 1'b1;
         csr_index <= REG_ROWS;
         csr_wdata <= rows;
         cur_rows   = rows;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      phases++;
   endtask

   initial begin : rsp_side
      int gap;
      int span;
      bit calm;
      rsp_ready     <= 1'b1;
      hold_off_done <= 1'b0;
      span = 0;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if (span <= 0) begin
            calm = ($urandom_range(3) == 0);
            span = $urandom_range(400, 100);
         end
         span--;
         if (hold_off_go && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_ready     <= 1'b1;
            hold_off_done <= 1'b1;
         end else begin
            gap = pick_gap(calm);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      logic [CFG_W-1:0] new_cols;
      logic [CFG_W-1:0] new_rows;
      int               roll;
      int               frames;
      int               frame_len;
      int               count;
      int               live_pct;
      req_valid    <= 1'b0;
      req_cell_req <= 1'b0;
      csr_we       <= 1'b0;
      csr_index    <= REG_COLS;
      csr_wdata    <= '0;
      hold_off_go  <= 1'b0;
      reset        <= 1'b1;
      send_calm    = 1'b0;
      cells_total  = 0;
      random_cells = 0;
      phases       = 1;
      cur_cols     = CFG_W'(MAX_COLS);
      cur_rows     = CFG_W'(MAX_ROWS);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size: two halo rows plus a few inner cells, then cut short
      send_cells(2 * (MAX_COLS + 2) + $urandom_range(12, 3), 50);
      drain();

      // zero sizes act as a single inner cell
      write_regs(1'b1, '0, 1'b1, '0);
      foreach (SHAPES[s]) begin
         for (int k = 0; k < 9; k++) offer_cell(SHAPES[s][k]);
      end
      drain();

      while (random_cells < RANDOM_CELLS) begin
         roll = $urandom_range(9);
         if (roll == 0) new_cols = CFG_W'($urandom_range(1));
         else if (roll == 1) new_cols = CFG_W'($urandom_range(20, 9));
         else new_cols = CFG_W'($urandom_range(8, 1));
         roll = $urandom_range(9);
         if (roll == 0) new_rows = CFG_W'($urandom_range(1));
         else if (roll == 1) new_rows = CFG_W'($urandom_range(20, 9));
         else new_rows = CFG_W'($urandom_range(8, 1));
         roll = $urandom_range(5);
         write_regs(roll != 1, new_cols, roll != 0, new_rows);
         send_calm = ($urandom_range(3) == 0);
         frame_len = padded(cur_cols, MAX_COLS) * padded(cur_rows, MAX_ROWS);
         frames    = (frame_len > 100) ? 1 : $urandom_range(3, 1);
         for (int f = 1; f <= frames; f++) begin
            count = frame_len;
            if (f == frames && $urandom_range(5) == 0) begin
               count = $urandom_range(frame_len - 1, 1);
            end
            case ($urandom_range(5))
               0:       live_pct = 0;
               1:       live_pct = 100;
               2:       live_pct = 15;
               3:       live_pct = 35;
               default: live_pct = 50;
            endcase
            send_cells(count, live_pct);
            random_cells += count;
         end
         drain();
      end

      // narrow grids at and above the row limit, cut short
      send_calm = 1'b0;
      for (int k = 0; k < 3; k++) begin
         write_regs(1'b1, EXTREME_COLS[k], 1'b1, EXTREME_ROWS[k]);
         send_cells(padded(cur_cols, MAX_COLS) * EXTREME_LINES, 50);
         drain();
      end

      repeat (10) @(posedge clock);
      $display("Sent %0d cells under %0d register settings, incl. clamped sizes.",
               cells_total, phases);
      $display("Checked %0d next-state results, %0d of them closing a grid.",
               checked, grid_ends);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lgs_pkg.sv
rtl/lgs_line_ram.sv
rtl/lgs_window.sv
rtl/life_grid_step_stencil.sv
rtl/lgs_checker.sv
test/stencil_checker.sv
test/testbench.sv
